// ===== rtl/core/sn7s_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sn7s_pkg;

	localparam int VALUE_W = 32;
	localparam int ADDR_W  = 4;
	localparam int SEG_W   = 8;
	localparam int DIGIT_W = 4;
	localparam int QUOT_W  = 29;

	// floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int                 RECIP10_SHIFT = 35;

	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;

	typedef struct packed {
		logic capture;
		logic emit_clear;
		logic start_div;
		logic emit_digit;
		logic emit_minus;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic pos_end;
		logic quot_zero;
		logic negative;
	} sts_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 8'h7E;
			4'd1:    s = 8'h30;
			4'd2:    s = 8'h6D;
			4'd3:    s = 8'h79;
			4'd4:    s = 8'h33;
			4'd5:    s = 8'h5B;
			4'd6:    s = 8'h5F;
			4'd7:    s = 8'h70;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h7B;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sn7s_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sn7s_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sn7s_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sn7s_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sn7s_out_if;
	logic                          valid;
	logic                          ready;
	logic [sn7s_pkg::ADDR_W-1:0]   digit_address;
	logic [sn7s_pkg::SEG_W-1:0]    segment_pattern;
	logic                          last_write;

	modport source (output valid, output digit_address, output segment_pattern,
		output last_write, input ready);
	modport sink   (input valid, input digit_address, input segment_pattern,
		input last_write, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sn7s_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sn7s_dpath #(
	parameter int POSITION_COUNT = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [sn7s_pkg::VALUE_W-1:0] value,
	input  wire sn7s_pkg::cmd_t                      cmd,
	output sn7s_pkg::sts_t                           sts,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [sn7s_pkg::ADDR_W-1:0]              digit_address,
	output logic [sn7s_pkg::SEG_W-1:0]               segment_pattern,
	output logic                                     last_write
);

	localparam logic [sn7s_pkg::ADDR_W-1:0] PosLast  = sn7s_pkg::ADDR_W'(POSITION_COUNT);
	localparam logic [sn7s_pkg::ADDR_W-1:0] PosFirst = sn7s_pkg::ADDR_W'(1);

	logic [sn7s_pkg::VALUE_W-1:0] mag_q;
	logic                         neg_q;
	logic [sn7s_pkg::QUOT_W-1:0]  quot_q;
	logic [sn7s_pkg::ADDR_W-1:0]  pos_q;

	logic                         ovalid_q;
	logic [sn7s_pkg::ADDR_W-1:0]  addr_q;
	logic [sn7s_pkg::SEG_W-1:0]   seg_q;
	logic                         last_q;

	logic [2*sn7s_pkg::VALUE_W-1:0] prod;
	logic [sn7s_pkg::VALUE_W-1:0]   quot10;
	logic [sn7s_pkg::VALUE_W-1:0]   rem_full;
	logic [sn7s_pkg::DIGIT_W-1:0]   digit;
	logic                           out_free;
	logic                           emit_any;

	assign prod     = {{sn7s_pkg::VALUE_W{1'b0}}, mag_q}
		* {{sn7s_pkg::VALUE_W{1'b0}}, sn7s_pkg::RECIP10};
	// q*10 as (q << 3) + (q << 1)
	assign quot10   = {quot_q, 3'b000} + {2'b00, quot_q, 1'b0};
	assign rem_full = mag_q - quot10;
	assign digit    = rem_full[sn7s_pkg::DIGIT_W-1:0];

	assign out_free = !ovalid_q || out_ready;
	assign emit_any = cmd.emit_clear || cmd.emit_digit || cmd.emit_minus;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_q <= value[sn7s_pkg::VALUE_W-1] ? (~value + 32'd1) : value;
			neg_q <= value[sn7s_pkg::VALUE_W-1];
			pos_q <= PosFirst;
		end
		if (cmd.start_div) begin
			quot_q <= prod[sn7s_pkg::RECIP10_SHIFT +: sn7s_pkg::QUOT_W];
		end
		if (cmd.emit_clear) begin
			pos_q <= (pos_q == PosLast) ? PosFirst : pos_q + PosFirst;
		end
		if (cmd.emit_digit) begin
			mag_q <= {{(sn7s_pkg::VALUE_W-sn7s_pkg::QUOT_W){1'b0}}, quot_q};
			pos_q <= pos_q + PosFirst;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			addr_q <= pos_q;
			last_q <= cmd.last;
			if (cmd.emit_digit) begin
				seg_q <= sn7s_pkg::seg_of(digit);
			end else if (cmd.emit_minus) begin
				seg_q <= sn7s_pkg::SEG_MINUS;
			end else begin
				seg_q <= sn7s_pkg::SEG_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_any) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign sts.out_free  = out_free;
	assign sts.pos_end   = (pos_q == PosLast);
	assign sts.quot_zero = (quot_q == '0);
	assign sts.negative  = neg_q;

	assign out_valid       = ovalid_q;
	assign digit_address   = addr_q;
	assign segment_pattern = seg_q;
	assign last_write      = last_q;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.emit_clear, cmd.start_div, cmd.emit_digit, cmd.emit_minus}))
		else $error("more than one datapath command at once");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_any |-> out_free)
		else $error("word loaded while output register is still held");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> (digit < 4'd10))
		else $error("remainder out of decimal range");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(emit_any) |-> (addr_q != '0) && (addr_q <= PosLast))
		else $error("digit address outside display");

endmodule

`default_nettype wire

// ===== rtl/core/sn7s_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sn7s_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sn7s_pkg::sts_t sts,
	output sn7s_pkg::cmd_t      cmd
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StClear = 3'd1;
	localparam logic [2:0] StDiv   = 3'd2;
	localparam logic [2:0] StDigit = 3'd3;
	localparam logic [2:0] StMinus = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       more_digits;
	logic       minus_next;

	assign more_digits = !sts.quot_zero && !sts.pos_end;
	assign minus_next  = sts.negative && !sts.pos_end;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			StIdle: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = StClear;
				end
			end
			StClear: begin
				if (sts.out_free) begin
					cmd.emit_clear = 1'b1;
					if (sts.pos_end) begin
						state_d = StDiv;
					end
				end
			end
			StDiv: begin
				cmd.start_div = 1'b1;
				state_d       = StDigit;
			end
			StDigit: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					cmd.last       = !more_digits && !minus_next;
					if (more_digits) begin
						state_d = StDiv;
					end else if (minus_next) begin
						state_d = StMinus;
					end else begin
						state_d = StIdle;
					end
				end
			end
			StMinus: begin
				if (sts.out_free) begin
					cmd.emit_minus = 1'b1;
					cmd.last       = 1'b1;
					state_d        = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> (state_q == StIdle))
		else $error("final word sent but controller did not return to idle");

	a_clear_before_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StDiv) |-> ($past(state_q) == StClear || $past(state_q) == StDigit))
		else $error("division started out of order");

endmodule

`default_nettype wire

// ===== rtl/core/signed_number_to_seven_segment_top.sv =====
// Each number taken yields P blanking writes first, then one word per decimal digit,
// computed in StDiv (divide-by-ten multiply) and then StDigit (remainder), and a minus
// word if negative and a position is left; P = DIGIT_COUNT held to 1..8. Digits beyond P are dropped.
// Reset (arst_n low) returns the controller to idle and drops any pending word;
// no state is kept between numbers.
`timescale 1ns / 1ps
`default_nettype none

module signed_number_to_seven_segment_top #(
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sn7s_in_if.sink    in,
	sn7s_out_if.source out
);

	localparam int PositionCount = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 8) ? 8 : DIGIT_COUNT);

	sn7s_pkg::cmd_t cmd;
	sn7s_pkg::sts_t sts;
	logic           in_ready;

	assign in.ready = in_ready;

	sn7s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sn7s_dpath #(
		.POSITION_COUNT (PositionCount)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (in.value),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out.valid),
		.out_ready       (out.ready),
		.digit_address   (out.digit_address),
		.segment_pattern (out.segment_pattern),
		.last_write      (out.last_write)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb;

	localparam int PLACES     = 8;
	localparam int LONG_HOLD  = 300;
	localparam int RAND_COUNT = 300;
	localparam int DRAIN      = 40;

	typedef struct packed {
		logic [sn7s_pkg::ADDR_W-1:0] addr;
		logic [sn7s_pkg::SEG_W-1:0]  seg;
		logic                        last;
	} seg_write_t;

	// typed = 1: write count and final write are known by inspection
	typedef struct packed {
		logic signed [sn7s_pkg::VALUE_W-1:0] value;
		logic                                typed;
		logic [4:0]                          count;
		logic [sn7s_pkg::ADDR_W-1:0]         tail_addr;
		logic [sn7s_pkg::SEG_W-1:0]          tail_seg;
	} number_row_t;

	localparam logic [sn7s_pkg::SEG_W-1:0] GLYPH [10] = '{
		8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
	};

	localparam logic [sn7s_pkg::VALUE_W-1:0] POW10 [10] = '{
		32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
		32'd10000000, 32'd100000000, 32'd1000000000
	};

	localparam int ROWS = 22;
	localparam number_row_t DIRECTED [ROWS] = '{
		'{32'sd0,           1'b1, 5'd9,  4'd1, 8'h7E},
		'{32'sd1,           1'b1, 5'd9,  4'd1, 8'h30},
		'{32'sd9,           1'b1, 5'd9,  4'd1, 8'h7B},
		'{-32'sd1,          1'b1, 5'd10, 4'd2, sn7s_pkg::SEG_MINUS},
		'{32'sd10,          1'b1, 5'd10, 4'd2, 8'h30},
		'{-32'sd10,         1'b1, 5'd11, 4'd3, sn7s_pkg::SEG_MINUS},
		'{32'sh7FFF_FFFF,   1'b1, 5'd16, 4'd8, 8'h33},
		'{32'sh8000_0000,   1'b1, 5'd16, 4'd8, 8'h33},
		'{32'sd99999999,    1'b1, 5'd16, 4'd8, 8'h7B},
		'{-32'sd99999999,   1'b1, 5'd16, 4'd8, 8'h7B},
		'{-32'sd9999999,    1'b1, 5'd16, 4'd8, sn7s_pkg::SEG_MINUS},
		'{32'sd100000000,   1'b1, 5'd16, 4'd8, 8'h7E},
		'{32'sd1234567890,  1'b0, 5'd0,  4'd0, 8'h00},
		'{-32'sd1234567890, 1'b0, 5'd0,  4'd0, 8'h00},
		'{32'sd12345678,    1'b0, 5'd0,  4'd0, 8'h00},
		'{-32'sd123,        1'b0, 5'd0,  4'd0, 8'h00},
		'{-32'sd2147483647, 1'b0, 5'd0,  4'd0, 8'h00},
		'{32'sh5555_5555,   1'b0, 5'd0,  4'd0, 8'h00},
		'{32'shAAAA_AAAA,   1'b0, 5'd0,  4'd0, 8'h00},
		'{32'sd5678,        1'b0, 5'd0,  4'd0, 8'h00},
		'{-32'sd4560,       1'b0, 5'd0,  4'd0, 8'h00},
		'{32'sd1000000,     1'b0, 5'd0,  4'd0, 8'h00}
	};

	logic clk;
	logic arst_n;

	sn7s_in_if  number_ch ();
	sn7s_out_if write_ch ();

	signed_number_to_seven_segment_top #(
		.DIGIT_COUNT(PLACES)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (number_ch),
		.out    (write_ch)
	);

	seg_write_t pending_writes [$];
	int         mismatches;
	int         numbers_taken;
	int         writes_checked;
	int         negatives_taken;
	int         clipped_taken;
	bit         gaps_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Queue every write the number causes; return the count and whether digits were dropped.
	task automatic predict_writes(input logic signed [sn7s_pkg::VALUE_W-1:0] v, output int n,
		output bit clipped);
		logic [sn7s_pkg::VALUE_W-1:0] mag;
		seg_write_t                   staged [16];
		int                           places;
		int                           pos;
		n = 0;
		places = PLACES < 1 ? 1 : (PLACES > 8 ? 8 : PLACES);
		mag = v[sn7s_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
		clipped = places < 10 && mag >= POW10[places];
		for (pos = 1; pos <= places; pos++) begin
			staged[n] = '{sn7s_pkg::ADDR_W'(pos), sn7s_pkg::SEG_BLANK, 1'b0};
			n++;
		end
		if (mag == 0) begin
			staged[n] = '{sn7s_pkg::ADDR_W'(1), GLYPH[0], 1'b0};
			n++;
		end else begin
			pos = 1;
			while (mag != 0 && pos <= places) begin
				staged[n] = '{sn7s_pkg::ADDR_W'(pos), GLYPH[mag % 10], 1'b0};
				n++;
				mag = mag / 10;
				pos++;
			end
			if (v[sn7s_pkg::VALUE_W-1] && pos <= places) begin
				staged[n] = '{sn7s_pkg::ADDR_W'(pos), sn7s_pkg::SEG_MINUS, 1'b0};
				n++;
			end
		end
		staged[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_writes.push_back(staged[i]);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 15);
		if (!gaps_on || roll < 10)
			return 0;
		if (roll < 15)
			return $urandom_range(1, 3);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [sn7s_pkg::VALUE_W-1:0] pick_value();
		logic [sn7s_pkg::VALUE_W-1:0] r;
		r = '0;
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: r = $urandom_range(0, 99);
			3: r = $urandom_range(0, 99999999);
			4: r = POW10[$urandom_range(0, 9)] - 1 + $urandom_range(0, 2);
			default: r = $urandom_range(0, 9999);
		endcase
		if ($urandom_range(0, 1))
			r = ~r + 1'b1;
		return r;
	endfunction

	// Offer one number and return once it is taken, with the number of writes it causes.
	task automatic offer_number(input logic signed [sn7s_pkg::VALUE_W-1:0] v, output int n);
		int  gap;
		bit  clipped;
		gap = pick_gap();
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do @(posedge clk); while (!number_ch.ready);
		predict_writes(v, n, clipped);
		numbers_taken++;
		if (v[sn7s_pkg::VALUE_W-1])
			negatives_taken++;
		if (clipped)
			clipped_taken++;
	endtask

	initial begin : stimulus
		int               n;
		seg_write_t       tail;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		mismatches = 0;
		numbers_taken = 0;
		writes_checked = 0;
		negatives_taken = 0;
		clipped_taken = 0;
		number_ch.valid <= 1'b0;
		number_ch.value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++) begin
			offer_number(DIRECTED[i].value, n);
			if (DIRECTED[i].typed) begin
				tail = pending_writes[pending_writes.size() - 1];
				if (n != int'(DIRECTED[i].count))
					report_mismatch($sformatf("%0d: predicted %0d writes, table says %0d",
						DIRECTED[i].value, n, DIRECTED[i].count));
				if (tail.addr !== DIRECTED[i].tail_addr || tail.seg !== DIRECTED[i].tail_seg)
					report_mismatch($sformatf("%0d: predicted final write %0d/%02h",
						DIRECTED[i].value, tail.addr, tail.seg));
			end
		end

		gaps_on = 1'b1;
		for (int i = 0; i < RAND_COUNT; i++) begin
			// run a stretch without any idling on either side
			gaps_on = !(i >= 150 && i < 180);
			offer_number(pick_value(), n);
			if (i == 220) begin
				number_ch.valid <= 1'b0;
				while (pending_writes.size() != 0) @(posedge clk);
			end
		end
		number_ch.valid <= 1'b0;

		while (pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("tb: %0d numbers taken (%0d negative, %0d with dropped digits)",
			numbers_taken, negatives_taken, clipped_taken);
		$display("tb: %0d digit writes checked, %0d mismatches", writes_checked, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : write_sink
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		write_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			// hold off long enough for the block to back up and stall its input
			if (!held && numbers_taken >= 60) begin
				held = 1'b1;
				write_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (stall > 0) begin
				write_ch.ready <= 1'b0;
				stall--;
			end else begin
				write_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		seg_write_t want;
		if (arst_n && write_ch.valid && write_ch.ready) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write %0d/%02h last %0b",
					write_ch.digit_address, write_ch.segment_pattern, write_ch.last_write));
			end else begin
				want = pending_writes.pop_front();
				writes_checked++;
				if (write_ch.digit_address !== want.addr)
					report_mismatch($sformatf("digit_address %0d, expected %0d",
						write_ch.digit_address, want.addr));
				if (write_ch.segment_pattern !== want.seg)
					report_mismatch($sformatf("segment_pattern %02h, expected %02h",
						write_ch.segment_pattern, want.seg));
				if (write_ch.last_write !== want.last)
					report_mismatch($sformatf("last_write %0b, expected %0b",
						write_ch.last_write, want.last));
			end
		end
	end

	initial begin : watchdog
		#10ms;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
